/* sv/gha_pkg.sv */
// Shared types and constants for the generational handle allocator.
`timescale 1ns / 1ps

package gha_pkg;

  localparam int NUM_SLOTS = 256;
  localparam int SLOT_W    = 8;
  localparam int VER_W     = 16;
  localparam int CNT_W     = 9;

  typedef enum logic [1:0] {
    REQ_CREATE  = 2'd0,
    REQ_DESTROY = 2'd1,
    REQ_CHECK   = 2'd2,
    REQ_LOOKUP  = 2'd3
  } req_type_t;

  typedef struct packed {
    logic accept;
    logic fetch;
    logic exec;
  } cmd_t;

  typedef struct packed {
    logic need_fetch;
    logic out_free;
  } status_t;

endpackage

/* sv/gha_ifs.sv */
// Request and response channel interfaces for the handle allocator.
`timescale 1ns / 1ps

interface gha_req_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 req_type;
  logic [gha_pkg::SLOT_W-1:0] slot_index;
  logic [gha_pkg::VER_W-1:0]  handle_version;

  modport source (output valid, req_type, slot_index, handle_version, input ready);
  modport sink   (input valid, req_type, slot_index, handle_version, output ready);
endinterface

interface gha_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       ok;
  logic [gha_pkg::SLOT_W-1:0] out_index;
  logic [gha_pkg::VER_W-1:0]  out_version;
  logic [gha_pkg::CNT_W-1:0]  live_count;
  logic [gha_pkg::CNT_W-1:0]  capacity;

  modport source (output valid, ok, out_index, out_version, live_count, capacity,
                  input ready);
  modport sink   (input valid, ok, out_index, out_version, live_count, capacity,
                  output ready);
endinterface

/* sv/gha_ctrl.sv */
// Sequencing state machine for the handle allocator.
`timescale 1ns / 1ps

module gha_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  gha_pkg::status_t status,
  output gha_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_FETCH = 3'b010,
    S_EXEC  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) begin
          state_nxt = status.need_fetch ? S_FETCH : S_EXEC;
        end
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (status.out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* sv/gha_dp.sv */
// Datapath: version table, free list, counters and result register.
`timescale 1ns / 1ps

module gha_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  gha_pkg::cmd_t              cmd,
  output gha_pkg::status_t           status,
  input  logic [1:0]                 in_req_type,
  input  logic [gha_pkg::SLOT_W-1:0] in_slot_index,
  input  logic [gha_pkg::VER_W-1:0]  in_handle_version,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic                       out_ok,
  output logic [gha_pkg::SLOT_W-1:0] out_index,
  output logic [gha_pkg::VER_W-1:0]  out_version,
  output logic [gha_pkg::CNT_W-1:0]  out_live_count,
  output logic [gha_pkg::CNT_W-1:0]  out_capacity
);

  // version table entry: {live, version}
  logic [gha_pkg::VER_W:0]    vt_mem [gha_pkg::NUM_SLOTS];
  logic [gha_pkg::SLOT_W-1:0] ff_mem [gha_pkg::NUM_SLOTS];

  gha_pkg::req_type_t         req_type_r;
  logic [gha_pkg::SLOT_W-1:0] slot_r;
  logic [gha_pkg::VER_W-1:0]  ver_r;
  logic [gha_pkg::VER_W:0]    vt_rd_r;
  logic [gha_pkg::SLOT_W-1:0] ff_rd_r;

  logic [gha_pkg::SLOT_W-1:0] head_r, head_nxt;
  logic [gha_pkg::SLOT_W-1:0] tail_r, tail_nxt;
  logic [gha_pkg::CNT_W-1:0]  free_count_r, free_count_nxt;
  logic [gha_pkg::CNT_W-1:0]  next_fresh_r, next_fresh_nxt;

  logic                       out_valid_r;
  logic                       ok_r;
  logic [gha_pkg::SLOT_W-1:0] oidx_r;
  logic [gha_pkg::VER_W-1:0]  over_r;
  logic [gha_pkg::CNT_W-1:0]  live_cnt_r;
  logic [gha_pkg::CNT_W-1:0]  cap_r;

  logic                       vt_re;
  logic [gha_pkg::SLOT_W-1:0] vt_ra;
  logic                       vt_we;
  logic [gha_pkg::SLOT_W-1:0] vt_wa;
  logic [gha_pkg::VER_W:0]    vt_wd;
  logic                       ff_we;

  logic                       cur_live;
  logic [gha_pkg::VER_W-1:0]  cur_ver;
  logic                       slot_hit;
  logic                       handle_ok;
  logic [gha_pkg::VER_W-1:0]  bumped;
  logic                       res_ok;
  logic [gha_pkg::SLOT_W-1:0] res_idx;
  logic [gha_pkg::VER_W-1:0]  res_ver;

  assign status.need_fetch = (in_req_type == gha_pkg::REQ_CREATE) && (free_count_r != '0);
  assign status.out_free   = !out_valid_r || out_ready;

  assign vt_re = cmd.accept || cmd.fetch;
  assign vt_ra = cmd.accept ? in_slot_index : ff_rd_r;

  assign cur_live  = vt_rd_r[gha_pkg::VER_W];
  assign cur_ver   = vt_rd_r[gha_pkg::VER_W-1:0];
  assign slot_hit  = {1'b0, slot_r} < next_fresh_r;
  assign handle_ok = slot_hit && cur_live && (ver_r != '0) && (cur_ver == ver_r);
  assign bumped    = (cur_ver + 1'b1 == '0) ? gha_pkg::VER_W'(1) : cur_ver + 1'b1;

  always_comb begin
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    free_count_nxt = free_count_r;
    next_fresh_nxt = next_fresh_r;
    vt_we          = 1'b0;
    vt_wa          = slot_r;
    vt_wd          = {1'b0, bumped};
    ff_we          = 1'b0;
    res_ok         = 1'b0;
    res_idx        = '0;
    res_ver        = '0;
    unique case (req_type_r)
      gha_pkg::REQ_CREATE: begin
        if (free_count_r != '0) begin
          head_nxt       = head_r + 1'b1;
          free_count_nxt = free_count_r - 1'b1;
          vt_we          = 1'b1;
          vt_wa          = ff_rd_r;
          vt_wd          = {1'b1, cur_ver};
          res_ok         = 1'b1;
          res_idx        = ff_rd_r;
          res_ver        = cur_ver;
        end else if (next_fresh_r < gha_pkg::CNT_W'(gha_pkg::NUM_SLOTS)) begin
          next_fresh_nxt = next_fresh_r + 1'b1;
          vt_we          = 1'b1;
          vt_wa          = next_fresh_r[gha_pkg::SLOT_W-1:0];
          vt_wd          = {1'b1, gha_pkg::VER_W'(1)};
          res_ok         = 1'b1;
          res_idx        = next_fresh_r[gha_pkg::SLOT_W-1:0];
          res_ver        = gha_pkg::VER_W'(1);
        end
      end
      gha_pkg::REQ_DESTROY: begin
        if (handle_ok) begin
          vt_we          = 1'b1;
          ff_we          = 1'b1;
          tail_nxt       = tail_r + 1'b1;
          free_count_nxt = free_count_r + 1'b1;
          res_ok         = 1'b1;
        end
      end
      gha_pkg::REQ_CHECK: begin
        res_ok = handle_ok;
      end
      gha_pkg::REQ_LOOKUP: begin
        res_idx = slot_r;
        res_ok  = slot_hit;
        res_ver = slot_hit ? cur_ver : '0;
      end
      default: res_ok = 1'b0;
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (vt_re) begin
      vt_rd_r <= vt_mem[vt_ra];
    end
    if (cmd.exec && vt_we) begin
      vt_mem[vt_wa] <= vt_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ff_rd_r <= ff_mem[head_r];
    end
    if (cmd.exec && ff_we) begin
      ff_mem[tail_r] <= slot_r;
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_type_r <= gha_pkg::req_type_t'(in_req_type);
      slot_r     <= in_slot_index;
      ver_r      <= in_handle_version;
    end
    if (cmd.exec) begin
      ok_r       <= res_ok;
      oidx_r     <= res_idx;
      over_r     <= res_ver;
      live_cnt_r <= next_fresh_nxt - free_count_nxt;
      cap_r      <= next_fresh_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r       <= '0;
      tail_r       <= '0;
      free_count_r <= '0;
      next_fresh_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.exec) begin
        head_r       <= head_nxt;
        tail_r       <= tail_nxt;
        free_count_r <= free_count_nxt;
        next_fresh_r <= next_fresh_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_ok         = ok_r;
  assign out_index      = oidx_r;
  assign out_version    = over_r;
  assign out_live_count = live_cnt_r;
  assign out_capacity   = cap_r;

endmodule

/* sv/generational_handle_allocator.sv */
// Flow: an accepted request enters the execute state, which waits for a free
//   result register, then sets result valid; a create served from the free list
//   first passes the fetch state (slot read, then dependent version-table read).
// One request at a time; the registered version-table read precedes write-back.
// Reset: synchronous active-low rst_n clears counters and result valid; version
//   table (with its live flags) and free-list storage are not cleared.
`timescale 1ns / 1ps

module generational_handle_allocator (
  input  logic      clk,
  input  logic      rst_n,
  gha_req_if.sink   in_req,
  gha_rsp_if.source out_rsp
);

  gha_pkg::cmd_t    cmd;
  gha_pkg::status_t status;

  gha_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_req.ready),
    .status   (status),
    .cmd      (cmd)
  );

  gha_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_req_type       (in_req.req_type),
    .in_slot_index     (in_req.slot_index),
    .in_handle_version (in_req.handle_version),
    .out_ready         (out_rsp.ready),
    .out_valid         (out_rsp.valid),
    .out_ok            (out_rsp.ok),
    .out_index         (out_rsp.out_index),
    .out_version       (out_rsp.out_version),
    .out_live_count    (out_rsp.live_count),
    .out_capacity      (out_rsp.capacity)
  );

endmodule
